// ----- rtl/sa_tlb_pkg.sv -----
package sa_tlb_pkg;

    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 8;
    localparam int M_HIT_BIT   = 0;
    localparam int M_WAY_LSB   = 1;
    localparam int M_WAY_W     = 2;
    localparam int M_EVICT_BIT = 3;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } sa_tlb_cmd_t;

    typedef struct packed {
        logic out_stall;
    } sa_tlb_sts_t;

endpackage

// ----- rtl/set_assoc_tlb_hit_check_top.sv -----
// Set-associative TLB lookup with LRU or FIFO replacement. Each input beat
// carries a virtual address; the set index and tag are taken from it, the
// set's row of tags, ages and round-robin pointer is read from a single row
// RAM, the tags are compared in parallel, on a miss the chosen way is filled
// or replaced, and the row is written back. One lookup occupies the block
// through three steps (accept and RAM read, compare, update and write-back),
// set by the read-modify-write of the set's row in that RAM. The result beat
// is loaded at the write-back edge, and the write-back waits for as long as
// the previous result beat is still held in the output register. A new address
// is accepted from the cycle after the write-back, also while the previous
// result beat is still waiting in the output register. The result beat gives
// hit, the way used and whether a valid entry was evicted. cfg_wdata selects
// the policy (0 least recently used, 1 first in first out); the user must see
// that it is written only while no lookup is in flight, since the block
// itself does not enforce this.
module set_assoc_tlb_hit_check_top #(
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 4,
    parameter int OFFSET_BITS = 21,
    parameter int ADDR_BITS   = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sa_tlb_pkg::S_TDATA_W-1:0] s_tdata,   // virt_addr[63:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sa_tlb_pkg::M_TDATA_W-1:0] m_tdata    // hit, way_used[1:0], evicted, zeros
);

    sa_tlb_pkg::sa_tlb_cmd_t cmd;
    sa_tlb_pkg::sa_tlb_sts_t sts;
    logic                    hit;
    logic [sa_tlb_pkg::M_WAY_W-1:0] way_used;
    logic                    evicted;

    sa_tlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sa_tlb_dpath #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .hit       (hit),
        .way_used  (way_used),
        .evicted   (evicted)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[sa_tlb_pkg::M_HIT_BIT] = hit;
        m_tdata[sa_tlb_pkg::M_WAY_LSB +: sa_tlb_pkg::M_WAY_W] = way_used;
        m_tdata[sa_tlb_pkg::M_EVICT_BIT] = evicted;
    end

endmodule

// ----- rtl/sa_tlb_ram.sv -----
module sa_tlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sa_tlb_ctrl.sv -----
module sa_tlb_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  sa_tlb_pkg::sa_tlb_sts_t sts,
    output sa_tlb_pkg::sa_tlb_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   s_tready_next;

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next    = ST_LOOKUP;
                    s_tready_next = 1'b0;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!sts.out_stall) begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready   = s_tready_reg;
    assign cmd.accept = s_tvalid && s_tready_reg;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.commit = (state_reg == ST_UPDATE) && !sts.out_stall;

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("Input ready raised outside the idle state.");

    a_commit_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_tready)
        else $error("Input not reopened after the update was committed.");

endmodule

// ----- rtl/sa_tlb_dpath.sv -----
module sa_tlb_dpath #(
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 4,
    parameter int OFFSET_BITS = 21,
    parameter int ADDR_BITS   = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sa_tlb_pkg::sa_tlb_cmd_t             cmd,
    output sa_tlb_pkg::sa_tlb_sts_t             sts,
    input  logic [sa_tlb_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic                                hit,
    output logic [sa_tlb_pkg::M_WAY_W-1:0]      way_used,
    output logic                                evicted
);

    localparam int IDX_BITS  = $clog2(NUM_SETS);
    localparam int SET_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int TAG_SHIFT = OFFSET_BITS + IDX_BITS;
    localparam int TAG_W     = (ADDR_BITS > TAG_SHIFT) ? (ADDR_BITS - TAG_SHIFT) : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W     = WAY_W;
    localparam int AGE_LSB   = NUM_WAYS * TAG_W;
    localparam int PTR_LSB   = NUM_WAYS * (TAG_W + AGE_W);
    localparam int ROW_W     = PTR_LSB + WAY_W;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(NUM_WAYS - 1);
    localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(NUM_WAYS - 1);

    logic [63:0]       addr_m;
    logic [63:0]       set_sh;
    logic [63:0]       tag_sh;
    logic [SET_W-1:0]  set_raw;
    logic [SET_W:0]    set_ext;
    logic [SET_W-1:0]  set_in;
    logic [TAG_W-1:0]  tag_in;

    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              policy_reg;
    logic [NUM_WAYS-1:0] valid_reg [NUM_SETS];
    logic [NUM_WAYS-1:0] hit_vec_reg;
    logic [NUM_WAYS-1:0] hit_vec;

    logic [ROW_W-1:0]  row_rd;
    logic [ROW_W-1:0]  row_wr;
    logic [NUM_WAYS-1:0] vld;
    logic              row_live;
    logic [TAG_W-1:0]  tag_rd  [NUM_WAYS];
    logic [AGE_W-1:0]  age_rd  [NUM_WAYS];
    logic [AGE_W-1:0]  age_new [NUM_WAYS];
    logic [WAY_W-1:0]  ptr_rd;
    logic [WAY_W-1:0]  ptr_new;

    logic              any_hit;
    logic              found_free;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  lru_way;
    logic [NUM_WAYS-1:0] is_max;
    logic [WAY_W-1:0]  way_sel;
    logic [AGE_W-1:0]  ref_age;
    logic              evict;
    logic [WAY_W+1:0]  way_ext;

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic              hit_reg;
    logic [sa_tlb_pkg::M_WAY_W-1:0] way_reg;
    logic              evict_reg;

    // Address split: set index above the page offset, tag above the index.
    assign addr_m  = s_tdata & ADDR_MASK;
    assign set_sh  = addr_m >> OFFSET_BITS;
    assign tag_sh  = addr_m >> TAG_SHIFT;
    assign tag_in  = tag_sh[TAG_W-1:0];
    assign set_raw = (IDX_BITS == 0) ? '0 : set_sh[SET_W-1:0];
    assign set_ext = {1'b0, set_raw};
    assign set_in  = (set_ext >= (SET_W+1)'(NUM_SETS)) ?
                     SET_W'(set_ext - (SET_W+1)'(NUM_SETS)) : set_raw;

    sa_tlb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (cmd.accept),
        .raddr (set_in),
        .rdata (row_rd)
    );

    // A row that has never been written holds no valid way; its ages and
    // pointer then read as zero.
    assign vld      = valid_reg[set_reg];
    assign row_live = |vld;
    assign ptr_rd   = row_live ? row_rd[PTR_LSB +: WAY_W] : '0;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            tag_rd[w]  = row_rd[w*TAG_W +: TAG_W];
            age_rd[w]  = row_live ? row_rd[AGE_LSB + w*AGE_W +: AGE_W] : '0;
            hit_vec[w] = vld[w] && (tag_rd[w] == tag_reg);
        end
    end

    always_comb begin
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (hit_vec_reg[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!vld[w]) begin
                free_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            is_max[w] = 1'b1;
            for (int v = 0; v < NUM_WAYS; v++) begin
                if (age_rd[v] > age_rd[w]) begin
                    is_max[w] = 1'b0;
                end
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (is_max[w]) begin
                lru_way = WAY_W'(w);
            end
        end
    end

    assign any_hit    = |hit_vec_reg;
    assign found_free = ~&vld;
    assign evict      = !any_hit && !found_free;
    assign ref_age    = age_rd[hit_way];

    always_comb begin
        if (any_hit) begin
            way_sel = hit_way;
        end else if (found_free) begin
            way_sel = free_way;
        end else if (policy_reg) begin
            way_sel = ptr_rd;
        end else begin
            way_sel = lru_way;
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            age_new[w] = age_rd[w];
            if (!policy_reg) begin
                if (any_hit) begin
                    if (vld[w] && (age_rd[w] < ref_age)) begin
                        age_new[w] = age_rd[w] + 1'b1;
                    end
                end else if ((WAY_W'(w) != way_sel) && vld[w] && (age_rd[w] < AGE_MAX)) begin
                    age_new[w] = age_rd[w] + 1'b1;
                end
                if (WAY_W'(w) == way_sel) begin
                    age_new[w] = '0;
                end
            end
        end
    end

    assign ptr_new = (policy_reg && !any_hit) ?
                     ((way_sel == WAY_LAST) ? '0 : WAY_W'(way_sel + 1'b1)) : ptr_rd;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_wr[w*TAG_W +: TAG_W] =
                (!any_hit && (WAY_W'(w) == way_sel)) ? tag_reg : tag_rd[w];
            row_wr[AGE_LSB + w*AGE_W +: AGE_W] = age_new[w];
        end
        row_wr[PTR_LSB +: WAY_W] = ptr_new;
    end

    assign way_ext = (WAY_W+2)'(way_sel);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
        if (cmd.lookup) begin
            hit_vec_reg <= hit_vec;
        end
        if (cmd.commit) begin
            hit_reg   <= any_hit;
            way_reg   <= way_ext[sa_tlb_pkg::M_WAY_W-1:0];
            evict_reg <= evict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++) begin
                valid_reg[s] <= '0;
            end
        end else begin
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
            if (cmd.commit && !any_hit) begin
                valid_reg[set_reg][way_sel] <= 1'b1;
            end
        end
    end

    assign m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign sts.out_stall = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign hit           = hit_reg;
    assign way_used      = way_reg;
    assign evicted       = evict_reg;

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $onehot0(hit_vec_reg))
        else $error("A tag is valid in more than one way of its set.");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && evict) |-> (&vld))
        else $error("An entry was replaced in a set that still had a free way.");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (m_tvalid && (hit == $past(any_hit))))
        else $error("Committed lookup did not appear on the result beat.");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_SETS    = 16;
    localparam int NUM_WAYS    = 4;
    localparam int OFFSET_BITS = 21;
    localparam int SET_BITS    = 4;
    localparam int TAG_BITS    = 39;
    localparam int POOL_SIZE   = 6;

    typedef enum bit {
        POLICY_LRU  = 1'b0,
        POLICY_FIFO = 1'b1
    } tlb_policy_e;

    typedef struct packed {
        bit       hit;
        bit [1:0] way;
        bit       evicted;
    } lookup_result_t;

    class tlb_lookup_checker;
        tlb_policy_e          policy = POLICY_LRU;
        bit [TAG_BITS-1:0]    tag_mem[NUM_SETS][NUM_WAYS];
        bit                   entry_valid[NUM_SETS][NUM_WAYS];
        bit [1:0]             lru_age[NUM_SETS][NUM_WAYS];
        bit [1:0]             rr_ptr[NUM_SETS];
        lookup_result_t       expected_lookups[$];
        int                   fail_count = 0;

        function void predict_lookup(bit [63:0] addr);
            int             set_idx;
            int             way;
            bit [TAG_BITS-1:0] tag;
            bit             hit;
            bit             free_found;
            bit             evicted;
            bit [1:0]       hit_age;
            lookup_result_t res;
            set_idx    = int'((addr >> OFFSET_BITS) % NUM_SETS);
            tag        = TAG_BITS'(addr >> (OFFSET_BITS + SET_BITS));
            hit        = 1'b0;
            free_found = 1'b0;
            evicted    = 1'b0;
            way        = 0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!hit && entry_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
                    hit = 1'b1;
                    way = w;
                end
            end
            if (hit) begin
                if (policy == POLICY_LRU) begin
                    hit_age = lru_age[set_idx][way];
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (entry_valid[set_idx][w] && lru_age[set_idx][w] < hit_age) begin
                            lru_age[set_idx][w]++;
                        end
                    end
                    lru_age[set_idx][way] = 2'd0;
                end
            end else begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (!free_found && !entry_valid[set_idx][w]) begin
                        free_found = 1'b1;
                        way = w;
                    end
                end
                if (!free_found) begin
                    evicted = 1'b1;
                    if (policy == POLICY_LRU) begin
                        way = 0;
                        for (int w = 1; w < NUM_WAYS; w++) begin
                            if (lru_age[set_idx][w] > lru_age[set_idx][way]) begin
                                way = w;
                            end
                        end
                    end else begin
                        way = int'(rr_ptr[set_idx]);
                    end
                end
                tag_mem[set_idx][way]     = tag;
                entry_valid[set_idx][way] = 1'b1;
                if (policy == POLICY_LRU) begin
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (w != way && entry_valid[set_idx][w]
                                && lru_age[set_idx][w] < NUM_WAYS - 1) begin
                            lru_age[set_idx][w]++;
                        end
                    end
                    lru_age[set_idx][way] = 2'd0;
                end else begin
                    rr_ptr[set_idx] = 2'((way + 1) % NUM_WAYS);
                end
            end
            res.hit     = hit;
            res.way     = 2'(way);
            res.evicted = evicted;
            expected_lookups.push_back(res);
        endfunction

        function void check_result(bit [sa_tlb_pkg::M_TDATA_W-1:0] beat);
            lookup_result_t got;
            lookup_result_t want;
            got.hit     = beat[sa_tlb_pkg::M_HIT_BIT];
            got.way     = beat[sa_tlb_pkg::M_WAY_LSB +: sa_tlb_pkg::M_WAY_W];
            got.evicted = beat[sa_tlb_pkg::M_EVICT_BIT];
            if (expected_lookups.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result beat with no lookup pending: hit=%0d way=%0d evicted=%0d",
                             $realtime, got.hit, got.way, got.evicted);
                end
            end else begin
                want = expected_lookups.pop_front();
                if (got.hit != want.hit || got.way != want.way
                        || got.evicted != want.evicted) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"%0t: mismatch: expected hit=%0d way=%0d evicted=%0d, ",
                                  "got hit=%0d way=%0d evicted=%0d"},
                                 $realtime, want.hit, want.way, want.evicted,
                                 got.hit, got.way, got.evicted);
                    end
                end
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic                             cfg_wdata = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [sa_tlb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [sa_tlb_pkg::M_TDATA_W-1:0] m_tdata;

    tlb_lookup_checker    chk = new();
    bit                   quiet = 1'b0;
    bit [TAG_BITS-1:0]    tag_pool[NUM_SETS][POOL_SIZE];

    set_assoc_tlb_hit_check_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                chk.predict_lookup(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                chk.check_result(m_tdata);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [63:0] mk_addr(bit [TAG_BITS-1:0] tag, bit [SET_BITS-1:0] set_idx,
                                          bit [OFFSET_BITS-1:0] offset);
        return {tag, set_idx, offset};
    endfunction

    function automatic bit [TAG_BITS-1:0] rand_tag();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[TAG_BITS-1:0];
    endfunction

    function automatic bit [63:0] rand_addr();
        int                set_idx;
        int                r;
        bit [TAG_BITS-1:0] tag;
        set_idx = $urandom_range(0, NUM_SETS - 1);
        tag     = tag_pool[set_idx][$urandom_range(0, POOL_SIZE - 1)];
        r       = $urandom_range(0, 99);
        if (r >= 93) begin
            return {$urandom, $urandom};
        end else if (r >= 85) begin
            tag = tag ^ (39'd1 << $urandom_range(0, TAG_BITS - 1));
        end
        return mk_addr(tag, 4'(set_idx), 21'($urandom));
    endfunction

    task automatic refresh_pool();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int k = 0; k < POOL_SIZE; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    tag_pool[s][k] = rand_tag();
                end
            end
        end
    endtask

    task automatic send_addr(bit [63:0] addr);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chk.expected_lookups.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_policy(tlb_policy_e mode);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        chk.policy = mode;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int run;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = pick_gap();
            run   = $urandom_range(1, 12);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            repeat (run - 1) @(negedge aclk);
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        tlb_policy_e phase_policy[6];
        phase_policy = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_FIFO,
                         POLICY_LRU};
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int k = 0; k < POOL_SIZE; k++) begin
                tag_pool[s][k] = rand_tag();
            end
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_policy(POLICY_LRU);
        send_addr(64'h0);
        send_addr(mk_addr('0, 4'd0, '1));
        send_addr('1);
        send_addr('1);
        send_addr(mk_addr(39'h1, 4'd5, '0));
        send_addr(mk_addr(39'h2A_AAAA_AAAA, 4'd5, 21'h12345));
        send_addr(mk_addr(39'h55_5555_5555, 4'd5, '1));
        send_addr(mk_addr('1, 4'd5, '0));
        send_addr(mk_addr(39'h1, 4'd5, '0));
        send_addr(mk_addr(39'h40_0000_0000, 4'd5, '0));
        send_addr(mk_addr(39'h55_5555_5555, 4'd5, '0));
        send_addr(mk_addr(39'h3, 4'd5, '0));
        send_addr(mk_addr('0, 4'd15, '1));

        set_policy(POLICY_FIFO);
        send_addr(mk_addr(39'h7, 4'd5, '0));
        send_addr(mk_addr(39'h7, 4'd5, '1));
        send_addr(mk_addr(39'h8, 4'd5, '0));
        send_addr(mk_addr(39'h10, 4'd9, '0));
        send_addr(mk_addr(39'h11, 4'd9, '0));
        send_addr(mk_addr(39'h12, 4'd9, '0));
        send_addr(mk_addr(39'h13, 4'd9, '0));
        send_addr(mk_addr(39'h14, 4'd9, '0));
        send_addr(mk_addr(39'h12, 4'd9, '0));

        for (int p = 0; p < 6; p++) begin
            set_policy(phase_policy[p]);
            quiet = (p == 2 || p == 4);
            refresh_pool();
            repeat (280) send_addr(rand_addr());
        end

        quiet = 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        if (chk.fail_count == 0 && chk.expected_lookups.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
